### sv/lirt_pkg.sv
`default_nettype none
package lirt_pkg;

  localparam int MAX_LEN    = 1024;
  localparam int VALUE_BITS = 16;
  localparam int KEY_BITS   = 16;
  localparam int ADDR_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W      = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SRCH,
    ST_SCMP,
    ST_FIN
  } lirt_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic wr_first;
    logic wr_append;
    logic set_ovf;
    logic srch_init;
    logic srch_read;
    logic srch_step;
    logic wr_found;
    logic load_out;
  } lirt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_first;
    logic want_append;
    logic full;
    logic srch_open;
  } lirt_status_t;

endpackage
`default_nettype wire

### sv/lirt_ctrl.sv
`default_nettype none
module lirt_ctrl
  import lirt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire lirt_status_t status,
  output lirt_cmd_t         cmd
);

  lirt_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.is_first || status.want_append) state_nxt = ST_FIN;
        else state_nxt = ST_SRCH;
      end
      ST_SRCH: begin
        if (status.srch_open) state_nxt = ST_SCMP;
        else state_nxt = ST_FIN;
      end
      ST_SCMP: begin
        state_nxt = ST_SRCH;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
      end
      ST_DECIDE: begin
        if (status.is_first) begin
          cmd.wr_first = 1'b1;
        end else if (status.want_append) begin
          cmd.set_ovf   = status.full;
          cmd.wr_append = !status.full;
        end else begin
          cmd.srch_init = 1'b1;
        end
      end
      ST_SRCH: begin
        cmd.srch_read = status.srch_open;
        cmd.wr_found  = !status.srch_open;
      end
      ST_SCMP: begin
        cmd.srch_step = 1'b1;
      end
      ST_FIN: begin
        cmd.load_out = out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/lirt_dp.sv
`default_nettype none
module lirt_dp
  import lirt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic [KEY_BITS-1:0]   in_side_key,
  input  wire logic                  in_start_req,
  input  wire lirt_cmd_t             cmd,
  output lirt_status_t               status,
  output logic [CNT_W-1:0]           out_run_length,
  output logic                       out_overflow
);

  logic [VALUE_BITS-1:0] tail_mem [MAX_LEN];

  logic [VALUE_BITS-1:0] val_r, last_r, rd_data_r;
  logic [KEY_BITS-1:0]   prev_key_r;
  logic                  start_r, keq_r, ovf_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      lo_r, hi1_r;
  logic [ADDR_W-1:0]     mid_r, mid;
  logic [CNT_W:0]        mid_sum;
  logic [ADDR_W-1:0]     found_idx, last_idx;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [CNT_W-1:0]      run_length_r;
  logic                  overflow_r;

  assign last_idx = ADDR_W'(count_r - CNT_W'(1));

  // hi1 is the inclusive upper bound plus one; the midpoint floors (lo + hi) / 2
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi1_r} - (CNT_W+1)'(1);
  assign mid     = mid_sum[ADDR_W:1];

  // a search that runs off the end lands on the last tail
  assign found_idx = (lo_r >= count_r) ? last_idx : ADDR_W'(lo_r);

  assign status.is_first    = start_r || (count_r == '0);
  assign status.want_append = (val_r > last_r) || keq_r;
  assign status.full        = (count_r >= CNT_W'(MAX_LEN));
  assign status.srch_open   = (lo_r < hi1_r);

  always_comb begin
    wr_en   = cmd.wr_first || cmd.wr_append || cmd.wr_found;
    wr_addr = '0;
    if (cmd.wr_append) wr_addr = ADDR_W'(count_r);
    else if (cmd.wr_found) wr_addr = found_idx;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.wr_first) count_nxt = CNT_W'(1);
    else if (cmd.wr_append) count_nxt = count_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) tail_mem[wr_addr] <= val_r;
    if (cmd.srch_read) rd_data_r <= tail_mem[mid];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      prev_key_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.capture) prev_key_r <= in_side_key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_r   <= in_value;
      start_r <= in_start_req;
      keq_r   <= (in_side_key == prev_key_r);
      ovf_r   <= 1'b0;
    end
    if (cmd.set_ovf) ovf_r <= 1'b1;
    if (cmd.wr_first || cmd.wr_append) last_r <= val_r;
    if (cmd.wr_found && (found_idx == last_idx)) last_r <= val_r;
    if (cmd.srch_init) begin
      lo_r  <= '0;
      hi1_r <= count_r;
    end
    if (cmd.srch_read) mid_r <= mid;
    if (cmd.srch_step) begin
      if (rd_data_r < val_r) lo_r <= CNT_W'(mid_r) + CNT_W'(1);
      else hi1_r <= CNT_W'(mid_r);
    end
    if (cmd.load_out) begin
      run_length_r <= count_r;
      overflow_r   <= ovf_r;
    end
  end

  assign out_run_length = run_length_r;
  assign out_overflow   = overflow_r;

endmodule
`default_nettype wire

### sv/longest_increasing_run_tracker.sv
// Flow: start, append and overflow items go from decide straight to finish; a replacing item
//   also runs the search of the tail memory, up to 11 probes, before it reaches finish.
// Handshake: a new transaction is taken only in idle, once the last one is through; the
//   search reads the tail memory once per probe, each read registered before its compare; a result still
//   waiting in the output register holds the controller in finish until it is taken.
// Reset (rst_n low, synchronous): tail count and previous key clear to zero, controller idles,
//   no result pending. Tail memory contents are not cleared; only written entries are read.
`default_nettype none
module longest_increasing_run_tracker
  import lirt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic [KEY_BITS-1:0]   in_side_key,
  input  wire logic                  in_start_req,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CNT_W-1:0]           out_run_length,
  output logic                       out_overflow
);

  // Command and status bundles between the sequencer and the tail datapath.
  lirt_cmd_t    cmd;
  lirt_status_t status;

  // Sequencer: take a transaction, classify it, run the halving search when the
  // item replaces a tail, then hold in finish until the result register frees up.
  lirt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: tail memory, tail count, cached last tail, search bounds and the
  // output register. The cached last tail saves a memory read on every append test.
  lirt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .in_side_key    (in_side_key),
    .in_start_req   (in_start_req),
    .cmd            (cmd),
    .status         (status),
    .out_run_length (out_run_length),
    .out_overflow   (out_overflow)
  );

endmodule
`default_nettype wire

### tb/longest_increasing_run_tracker_test.sv
`timescale 1ns / 100ps
`default_nettype none
module longest_increasing_run_tracker_test;
  import lirt_pkg::*;

  // Idle cycles with no transaction on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 3000;
  // Long receiver hold-off, long enough to back the block up into its input.
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int FILL_AFTER     = 50;
  localparam int TAIL_ITEMS     = 50;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct {
    logic [CNT_W-1:0] len;
    logic             ovf;
  } run_result_t;

  // One row of the directed part; typed rows carry their expected result,
  // the others take it from the tail-store predictor.
  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [KEY_BITS-1:0]   key;
    logic                  start;
    logic                  typed;
    logic [CNT_W-1:0]      len;
    logic                  ovf;
  } directed_row_t;

  localparam int N_DIRECTED = 17;

  directed_row_t directed_rows [N_DIRECTED] = '{
    // empty store after reset, no start flag: taken as the first tail
    '{16'h0064, 16'h0005, 1'b0, 1'b1, 11'd1, 1'b0},
    // smaller value, new key: replaces the only tail
    '{16'h0032, 16'h0006, 1'b0, 1'b0, 11'd0, 1'b0},
    // start with both fields at their maximum
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 11'd1, 1'b0},
    // zero value, same key as before: forced append leaves tails out of order
    '{16'h0000, 16'hFFFF, 1'b0, 1'b1, 11'd2, 1'b0},
    // search over out-of-order tails
    '{16'h0000, 16'h0000, 1'b0, 1'b0, 11'd0, 1'b0},
    '{16'h0001, 16'h0001, 1'b0, 1'b0, 11'd0, 1'b0},
    '{16'hFFFF, 16'h0002, 1'b0, 1'b0, 11'd0, 1'b0},
    '{16'h8000, 16'h0003, 1'b0, 1'b0, 11'd0, 1'b0},
    '{16'h8000, 16'h0003, 1'b0, 1'b0, 11'd0, 1'b0},
    // start with both fields at zero, then a key that repeats it
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 11'd1, 1'b0},
    '{16'h0000, 16'h0000, 1'b0, 1'b1, 11'd2, 1'b0},
    // equal value, new key: lower bound lands on an equal tail
    '{16'h0000, 16'h0001, 1'b0, 1'b0, 11'd0, 1'b0},
    // alternating bit patterns
    '{16'h5555, 16'h5555, 1'b1, 1'b1, 11'd1, 1'b0},
    '{16'hAAAA, 16'hAAAA, 1'b0, 1'b0, 11'd0, 1'b0},
    '{16'h5555, 16'h0000, 1'b0, 1'b0, 11'd0, 1'b0},
    // start whose key matches the previous key: still clears the store
    '{16'hFFFF, 16'h0000, 1'b1, 1'b1, 11'd1, 1'b0},
    '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 11'd0, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_value;
  logic [KEY_BITS-1:0]   in_side_key;
  logic                  in_start_req;
  logic                  out_valid;
  logic                  out_ready;
  logic [CNT_W-1:0]      out_run_length;
  logic                  out_overflow;

  longest_increasing_run_tracker i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_side_key    (in_side_key),
    .in_start_req   (in_start_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_run_length (out_run_length),
    .out_overflow   (out_overflow)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Predictor state: a private copy of the tail store, its fill and the last key.
  logic [VALUE_BITS-1:0] tails [MAX_LEN];
  int                    tail_cnt;
  logic [KEY_BITS-1:0]   last_key;

  // Expected results, oldest first.
  run_result_t pending_runs [$];
  run_result_t oldest_run;

  int mismatch_count;
  int n_items;
  int n_results;
  int n_replace;
  int n_overflow;
  int peak_len;
  int burst_left;
  int n_random;
  bit fill_done;
  bit hold_done;
  int idle_cycles;

  // Advance the predicted tail store by one item and return the run length it reports.
  function automatic void advance_tails(input logic [VALUE_BITS-1:0] v,
                                        input logic [KEY_BITS-1:0] k,
                                        input logic st,
                                        output logic [CNT_W-1:0] len,
                                        output logic ovf);
    int lo;
    int hi;
    int mid;
    ovf = 1'b0;
    if (st || tail_cnt == 0) begin
      // start or empty store: value becomes the single tail
      tails[0] = v;
      tail_cnt = 1;
    end else if (v > tails[tail_cnt-1] || k == last_key) begin
      if (tail_cnt >= MAX_LEN) begin
        // refuse the append, hold the length at capacity
        ovf = 1'b1;
        n_overflow++;
      end else begin
        tails[tail_cnt] = v;
        tail_cnt++;
      end
    end else begin
      // lower bound: first tail >= v, searched as is even if tails are out of order
      lo = 0;
      hi = tail_cnt - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (tails[mid] < v) lo = mid + 1;
        else hi = mid - 1;
      end
      if (lo >= tail_cnt) lo = tail_cnt - 1;
      tails[lo] = v;
      n_replace++;
    end
    last_key = k;
    if (tail_cnt > peak_len) peak_len = tail_cnt;
    len = tail_cnt[CNT_W-1:0];
  endfunction

  // Pick a key that does not repeat the previous one, so no append is forced.
  function automatic logic [KEY_BITS-1:0] fresh_key();
    logic [KEY_BITS-1:0] k;
    k = KEY_BITS'($urandom);
    if (k == last_key) k = ~k;
    return k;
  endfunction

  // Pick a value above the last tail where there is room, else any value.
  function automatic logic [VALUE_BITS-1:0] rising_value();
    int top;
    if (tail_cnt == 0) return VALUE_BITS'($urandom);
    top = tails[tail_cnt-1];
    if (top >= (1 << VALUE_BITS) - 1) return VALUE_BITS'($urandom);
    return VALUE_BITS'($urandom_range((1 << VALUE_BITS) - 1, top + 1));
  endfunction

  task automatic note_mismatch(input string what, input logic [CNT_W-1:0] exp_len,
                               input logic exp_ovf);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch (%s): expected run_length %0d overflow %0d, got %0d %0d",
               $realtime, what, exp_len, exp_ovf, out_run_length, out_overflow);
  endtask

  // Offer one transaction; between bursts drop valid for a random gap first.
  task automatic send_item(input logic [VALUE_BITS-1:0] v, input logic [KEY_BITS-1:0] k,
                           input logic st, input logic typed,
                           input logic [CNT_W-1:0] typed_len, input logic typed_ovf);
    logic [CNT_W-1:0] len;
    logic             ovf;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
    end
    in_valid     <= 1'b1;
    in_value     <= v;
    in_side_key  <= k;
    in_start_req <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    n_items++;
    advance_tails(v, k, st, len, ovf);
    if (typed) pending_runs.push_back('{typed_len, typed_ovf});
    else pending_runs.push_back('{len, ovf});
  endtask

  // Pause the sender until every expected result is back.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_runs.size() != 0) @(posedge clk);
  endtask

  // Short sequence of mixed items; narrow sequences use a tiny value range to force ties.
  task automatic run_sequence(input int len, input bit narrow, input bit with_start);
    logic [VALUE_BITS-1:0] v;
    logic [KEY_BITS-1:0]   k;
    logic                  st;
    int                    pick;
    for (int i = 0; i < len; i++) begin
      st   = (i == 0 && with_start) || ($urandom_range(19, 0) == 0);
      pick = $urandom_range(99, 0);
      k    = fresh_key();
      if (pick < 40) begin
        v = rising_value();
      end else if (pick < 55) begin
        v = VALUE_BITS'($urandom);
        k = last_key;
      end else if (pick < 85 || tail_cnt == 0) begin
        v = VALUE_BITS'($urandom);
      end else begin
        // reuse an existing tail so the search meets an equal entry
        v = tails[$urandom_range(tail_cnt - 1, 0)];
      end
      if (narrow) v = v & VALUE_BITS'(4'hF);
      send_item(v, k, st, 1'b0, '0, 1'b0);
      n_random++;
    end
  endtask

  // Grow one sequence to capacity, mostly by repeated keys, then push past it.
  task automatic fill_store();
    logic [VALUE_BITS-1:0] v;
    logic [KEY_BITS-1:0]   k;
    int                    pick;
    int                    ovf_mark;
    send_item(VALUE_BITS'($urandom), fresh_key(), 1'b1, 1'b0, '0, 1'b0);
    n_random++;
    ovf_mark = n_overflow;
    while (!(tail_cnt == MAX_LEN && n_overflow - ovf_mark >= 12)) begin
      pick = $urandom_range(99, 0);
      if (pick < 88) begin
        v = VALUE_BITS'($urandom);
        k = last_key;
      end else if (pick < 94) begin
        v = rising_value();
        k = fresh_key();
      end else begin
        v = VALUE_BITS'($urandom);
        k = fresh_key();
      end
      send_item(v, k, 1'b0, 1'b0, '0, 1'b0);
      n_random++;
    end
  endtask

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_runs.size() == 0) begin
        note_mismatch("no result expected", '0, 1'b0);
      end else begin
        oldest_run = pending_runs.pop_front();
        if (out_run_length !== oldest_run.len || out_overflow !== oldest_run.ovf)
          note_mismatch("wrong field", oldest_run.len, oldest_run.ovf);
      end
    end
  end

  // Receiver: stall pattern that picks a new random mode each time its phase counter wraps, plus one long hold-off.
  initial begin
    int mode;
    int phase;
    out_ready = 1'b0;
    mode  = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && n_results >= 60) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (phase == 0) mode = $urandom_range(3, 0);
        phase = (phase + 1) % 50;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(1, 0);
          2: out_ready <= ($urandom_range(3, 0) == 0);
          default: out_ready <= phase[0];
        endcase
      end
    end
  end

  // Watchdog: abandon the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_runs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int post_fill;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    in_side_key  = '0;
    in_start_req = 1'b0;
    tail_cnt     = 0;
    last_key     = '0;
    burst_left   = 0;
    post_fill    = 0;
    // hold reset low, then release it once
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the table.
    for (int i = 0; i < N_DIRECTED; i++)
      send_item(directed_rows[i].value, directed_rows[i].key, directed_rows[i].start,
                directed_rows[i].typed, directed_rows[i].len, directed_rows[i].ovf);
    drain();

    // Random part: short sequences around one sequence that fills the store.
    while (!fill_done || post_fill < TAIL_ITEMS || n_random < RANDOM_ITEMS) begin
      if (!fill_done && n_random >= FILL_AFTER) begin
        drain();
        fill_store();
        fill_done = 1'b1;
      end else begin
        if ($urandom_range(7, 0) == 0) drain();
        if (fill_done) post_fill -= n_random;
        run_sequence($urandom_range(40, 1), $urandom_range(4, 0) == 0,
                     $urandom_range(9, 0) != 0);
        if (fill_done) post_fill += n_random;
      end
    end

    // Wait out every expected result, then let any stray output show up.
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d results: peak run %0d of %0d, %0d replacements,",
             n_items, n_results, peak_len, MAX_LEN, n_replace);
    $display("  %0d refused appends at capacity, %0d mismatches", n_overflow, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
sv/lirt_pkg.sv
sv/lirt_ctrl.sv
sv/lirt_dp.sv
sv/longest_increasing_run_tracker.sv
tb/longest_increasing_run_tracker_test.sv
